// ===== hw/rtl/tensor_gather_address_generator_top_macros.svh =====
// Assertion macros for the gather address engine checker.
// Used by tga_checker.sv; no other dependencies.
`ifndef TENSOR_GATHER_ADDRESS_GENERATOR_TOP_MACROS_SVH
`define TENSOR_GATHER_ADDRESS_GENERATOR_TOP_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define TGA_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tga checker: assertion failed");

// Next-cycle implication checked outside reset.
`define TGA_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tga checker: assertion failed");

`endif

// ===== hw/rtl/tga_pkg.sv =====
// Shared types and constants for the gather address engine.
// No dependencies; used by the top level, the checker and the testbench.
package tga_pkg;

   localparam int OFS_BITS    = 24;               // output offset / stride width
   localparam int ADDR_BITS   = 24;               // source address range
   localparam int INDEX_DEPTH = 4096;             // index store entries, power of two
   localparam int IDX_BITS    = $clog2(INDEX_DEPTH);
   localparam int EADDR_BITS  = 12;
   localparam int VAL_BITS    = 32;
   localparam int ROW_BITS    = 13;
   localparam int STRIDE_COUNT = 3;
   localparam int DIV_STAGES  = STRIDE_COUNT * OFS_BITS;
   localparam int RSP_LATENCY = DIV_STAGES + 4;
   localparam int CSR_IDX_BITS = 3;

   localparam logic [CSR_IDX_BITS-1:0] CSR_OUT_BATCH  = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_OUT_OUTER  = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_OUT_GATHER = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SRC_BATCH  = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SRC_OUTER  = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SRC_GATHER = 3'd5;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ROW_LENGTH = 3'd6;

   localparam logic FUNC_WRITE   = 1'b0;
   localparam logic FUNC_RESOLVE = 1'b1;

   // One stage of the coordinate split pipeline.
   typedef struct packed {
      logic                                 vld;
      logic                                 func;
      logic [EADDR_BITS-1:0]                eaddr;
      logic [VAL_BITS-1:0]                  eval;
      logic [STRIDE_COUNT-1:0][OFS_BITS-1:0] coord;
      logic [OFS_BITS-1:0]                  dvd;   // dividend, quotient shifts in
      logic [OFS_BITS-1:0]                  prem;  // partial remainder
   } div_stage_type;

   // One restoring-division step; on the last bit, store the quotient and
   // start the next split from the remainder.
   function automatic div_stage_type div_step(input div_stage_type p,
                                              input logic [OFS_BITS-1:0] stride,
                                              input int unsigned k,
                                              input logic last);
      div_stage_type      n;
      logic [OFS_BITS:0]  t;
      logic [OFS_BITS:0]  diff;
      logic               ge;
      n    = p;
      t    = {p.prem, p.dvd[OFS_BITS-1]};
      diff = t - {1'b0, stride};
      ge   = (t >= {1'b0, stride});
      n.prem = ge ? diff[OFS_BITS-1:0] : t[OFS_BITS-1:0];
      n.dvd  = {p.dvd[OFS_BITS-2:0], ge};
      if (last) begin
         n.coord[k] = (stride == '0) ? '0 : n.dvd;
         n.dvd      = n.prem;
         n.prem     = '0;
      end
      return n;
   endfunction

endpackage

// ===== hw/rtl/tensor_gather_address_generator_top.sv =====
// Top level of the batched rank-4 gather address engine.
// Depends on tga_pkg.
//
// Usage:
//  - Command channel: req_* carries one transaction, taken when start is high
//    and busy is low. busy never rises; a transaction can enter every cycle.
//  - req_func write stores req_entry_value at req_entry_addr in the index store
//    and produces no result. req_func resolve splits req_out_offset into four
//    coordinates and returns the source offset.
//  - Result channel: rsp_valid strobes for one cycle with rsp_src_offset and
//    rsp_bad_index for each resolve that was taken. Results come out in order,
//    one per cycle at most.
//  - Latency is set by the split pipeline: one quotient bit per stage over three
//    24-bit divisions (72 stages), then address, store read, multiply and sum.
//  - Config: csr_valid/csr_ready write one register by csr_index; csr_ready is
//    always high. Write config only while no resolve is in flight.
//  - Reset clears all valid bits and sets every register to 1. The index store
//    is not cleared; read only entries that were written.
//  - The receiver cannot stall; nothing here waits on it.
module tensor_gather_address_generator_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_func,
   input  logic [tga_pkg::EADDR_BITS-1:0]    req_entry_addr,
   input  logic signed [tga_pkg::VAL_BITS-1:0] req_entry_value,
   input  logic [tga_pkg::OFS_BITS-1:0]      req_out_offset,
   output logic                              rsp_valid,
   output logic [tga_pkg::ADDR_BITS-1:0]     rsp_src_offset,
   output logic                              rsp_bad_index,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [tga_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [31:0]                       csr_wdata
);
   import tga_pkg::*;

   localparam int PROD_BITS = OFS_BITS + OFS_BITS;
   localparam int RPROD_BITS = (VAL_BITS - 1) + OFS_BITS;
   localparam int SUM_BITS = RPROD_BITS + 2;
   localparam int RADDR_BITS = OFS_BITS + ROW_BITS + 1;

   logic [OFS_BITS-1:0] out_stride_ff [STRIDE_COUNT];
   logic [OFS_BITS-1:0] src_stride_ff [STRIDE_COUNT];
   logic [ROW_BITS-1:0] row_len_ff;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < STRIDE_COUNT; i++) begin
            out_stride_ff[i] <= OFS_BITS'(1);
            src_stride_ff[i] <= OFS_BITS'(1);
         end
         row_len_ff <= ROW_BITS'(1);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_OUT_BATCH:  out_stride_ff[0] <= csr_wdata[OFS_BITS-1:0];
            CSR_OUT_OUTER:  out_stride_ff[1] <= csr_wdata[OFS_BITS-1:0];
            CSR_OUT_GATHER: out_stride_ff[2] <= csr_wdata[OFS_BITS-1:0];
            CSR_SRC_BATCH:  src_stride_ff[0] <= csr_wdata[OFS_BITS-1:0];
            CSR_SRC_OUTER:  src_stride_ff[1] <= csr_wdata[OFS_BITS-1:0];
            CSR_SRC_GATHER: src_stride_ff[2] <= csr_wdata[OFS_BITS-1:0];
            CSR_ROW_LENGTH: row_len_ff       <= csr_wdata[ROW_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Coordinate split: one quotient bit per stage.
   div_stage_type div_in [DIV_STAGES];
   div_stage_type div_ff [DIV_STAGES];
   div_stage_type entry_stage;

   always_comb begin
      entry_stage       = '0;
      entry_stage.vld   = start && !busy;
      entry_stage.func  = req_func;
      entry_stage.eaddr = req_entry_addr;
      entry_stage.eval  = req_entry_value;
      entry_stage.dvd   = req_out_offset;
      for (int s = 0; s < DIV_STAGES; s++) begin
         div_in[s] = div_step((s == 0) ? entry_stage : div_ff[(s == 0) ? 0 : s - 1],
                              out_stride_ff[s / OFS_BITS], s / OFS_BITS,
                              (s % OFS_BITS) == (OFS_BITS - 1));
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
         if (reset) begin
            div_ff[s] <= '0;
         end else begin
            div_ff[s] <= div_in[s];
         end
      end
   end

   // Address stage: store location from batch and gathered coordinates, or the entry address for a write.
   logic                     a_vld_ff, a_vld_in;
   logic                     a_func_ff;
   logic [IDX_BITS-1:0]      a_addr_ff, a_addr_in;
   logic [VAL_BITS-1:0]      a_eval_ff;
   logic [OFS_BITS-1:0]      a_c0_ff, a_c1_ff, a_c3_ff;
   logic [RADDR_BITS-1:0]    raddr_full;

   always_comb begin
      raddr_full = RADDR_BITS'(div_ff[DIV_STAGES-1].coord[0] * row_len_ff)
                 + RADDR_BITS'(div_ff[DIV_STAGES-1].coord[2]);
      a_vld_in   = div_ff[DIV_STAGES-1].vld;
      a_addr_in  = (div_ff[DIV_STAGES-1].func == FUNC_WRITE)
                 ? IDX_BITS'(div_ff[DIV_STAGES-1].eaddr)
                 : IDX_BITS'(raddr_full);
   end

   always_ff @(posedge clock) begin
      a_func_ff <= div_ff[DIV_STAGES-1].func;
      a_addr_ff <= a_addr_in;
      a_eval_ff <= div_ff[DIV_STAGES-1].eval;
      a_c0_ff   <= div_ff[DIV_STAGES-1].coord[0];
      a_c1_ff   <= div_ff[DIV_STAGES-1].coord[1];
      a_c3_ff   <= div_ff[DIV_STAGES-1].dvd;
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= a_vld_in;
      end
   end

   // Index store: writes and reads take turns in transaction order.
   logic [VAL_BITS-1:0] index_mem [INDEX_DEPTH];
   logic [VAL_BITS-1:0] m_raw_ff;
   logic                m_vld_ff;
   logic [OFS_BITS-1:0] m_c0_ff, m_c1_ff, m_c3_ff;

   always_ff @(posedge clock) begin
      if (a_vld_ff && a_func_ff == FUNC_WRITE) begin
         index_mem[a_addr_ff] <= a_eval_ff;
      end
      m_raw_ff <= index_mem[a_addr_ff];
   end

   always_ff @(posedge clock) begin
      m_c0_ff <= a_c0_ff;
      m_c1_ff <= a_c1_ff;
      m_c3_ff <= a_c3_ff;
      if (reset) begin
         m_vld_ff <= 1'b0;
      end else begin
         m_vld_ff <= a_vld_ff && (a_func_ff == FUNC_RESOLVE);
      end
   end

   // Products with the source strides.
   logic                  p_vld_ff;
   logic                  p_neg_ff;
   logic [PROD_BITS-1:0]  p_batch_ff, p_outer_ff;
   logic [RPROD_BITS-1:0] p_gather_ff;
   logic [OFS_BITS-1:0]   p_inner_ff;

   always_ff @(posedge clock) begin
      p_neg_ff    <= m_raw_ff[VAL_BITS-1];
      p_batch_ff  <= m_c0_ff * src_stride_ff[0];
      p_outer_ff  <= m_c1_ff * src_stride_ff[1];
      p_gather_ff <= m_raw_ff[VAL_BITS-2:0] * src_stride_ff[2];
      p_inner_ff  <= m_c3_ff;
      if (reset) begin
         p_vld_ff <= 1'b0;
      end else begin
         p_vld_ff <= m_vld_ff;
      end
   end

   // Sum, range check, result register.
   logic [SUM_BITS-1:0] sum;
   logic                bad;
   logic                rsp_valid_ff;
   logic [ADDR_BITS-1:0] rsp_ofs_ff;
   logic                rsp_bad_ff;

   always_comb begin
      sum = SUM_BITS'(p_gather_ff) + SUM_BITS'(p_batch_ff)
          + SUM_BITS'(p_outer_ff) + SUM_BITS'(p_inner_ff);
      bad = p_neg_ff || (|sum[SUM_BITS-1:ADDR_BITS]);
   end

   always_ff @(posedge clock) begin
      rsp_ofs_ff <= bad ? '0 : sum[ADDR_BITS-1:0];
      rsp_bad_ff <= bad;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= p_vld_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_src_offset = rsp_ofs_ff;
   assign rsp_bad_index  = rsp_bad_ff;

endmodule

// ===== hw/rtl/tga_checker.sv =====
// Port-level checker for the gather address engine, bound to the top level.
// Depends on tga_pkg and tensor_gather_address_generator_top_macros.svh.
`include "tensor_gather_address_generator_top_macros.svh"

module tga_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                start,
   input logic                                busy,
   input logic                                req_func,
   input logic                                rsp_valid,
   input logic [tga_pkg::ADDR_BITS-1:0]       rsp_src_offset,
   input logic                                rsp_bad_index
);
   import tga_pkg::*;

   // A result only follows an accepted resolve.
   `TGA_ASSERT_IMP(a_rsp_has_cmd, rsp_valid, $past(start && !busy && req_func == FUNC_RESOLVE, RSP_LATENCY))
   // Index writes never produce a result.
   `TGA_ASSERT_IMP(a_write_silent, $past(start && !busy && req_func == FUNC_WRITE, RSP_LATENCY), !rsp_valid)
   // A flagged result carries a zero offset.
   `TGA_ASSERT_IMP(a_bad_zero, rsp_valid && rsp_bad_index, rsp_src_offset == '0)
   // The engine never pushes back.
   `TGA_ASSERT_NEXT(a_never_busy, 1'b1, !busy)

endmodule

bind tensor_gather_address_generator_top tga_checker u_tga_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .req_func       (req_func),
   .rsp_valid      (rsp_valid),
   .rsp_src_offset (rsp_src_offset),
   .rsp_bad_index  (rsp_bad_index)
);

// ===== dv/tensor_gather_address_generator_top_tb.sv =====
// Testbench for the batched rank-4 gather address engine: predicts each resolve
// and checks every result strobe in order. Depends on tga_pkg and the top level.
`timescale 1ns / 100ps

module tensor_gather_address_generator_top_tb;
   import tga_pkg::*;

   localparam logic [CSR_IDX_BITS-1:0] CSR_UNUSED = 3'd7;
   localparam int DRAIN_CYCLES = RSP_LATENCY + 8;

   typedef struct {
      logic                        func;
      logic [EADDR_BITS-1:0]       eaddr;
      logic signed [VAL_BITS-1:0]  evalue;
      logic [OFS_BITS-1:0]         ofs;
   } gather_req_type;

   typedef struct {
      logic [ADDR_BITS-1:0] src;
      logic                 bad;
   } gather_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_func = FUNC_WRITE;
   logic [EADDR_BITS-1:0] req_entry_addr = '0;
   logic signed [VAL_BITS-1:0] req_entry_value = '0;
   logic [OFS_BITS-1:0] req_out_offset = '0;
   logic rsp_valid;
   logic [ADDR_BITS-1:0] rsp_src_offset;
   logic rsp_bad_index;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_BITS-1:0] csr_index = '0;
   logic [31:0] csr_wdata = '0;

   // register shadow, indexed by CSR code
   logic [OFS_BITS-1:0] strides [6];
   logic [ROW_BITS-1:0] row_len;
   logic [VAL_BITS-1:0] index_mem [INDEX_DEPTH];
   bit                  slot_written [INDEX_DEPTH];

   gather_req_type pending_reqs [$];
   gather_rsp_type expected_rsps [$];
   gather_req_type cur;
   int issued = 0;
   int accepted = 0;
   int gap = 0;
   bit gaps_on = 1'b1;
   int errors = 0;

   tensor_gather_address_generator_top DUT (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Split an output offset into batch, outer, gathered coordinates and inner rest.
   function automatic void split_offset(input logic [OFS_BITS-1:0] ofs,
                                        output logic [63:0] c [3],
                                        output logic [63:0] rest);
      rest = 64'(ofs);
      for (int k = 0; k < 3; k++) begin
         if (strides[k] == 0) begin
            c[k] = 0;
         end else begin
            c[k] = rest / strides[k];
            rest = rest % strides[k];
         end
      end
   endfunction

   function automatic int gather_slot(input logic [OFS_BITS-1:0] ofs);
      logic [63:0] c [3];
      logic [63:0] rest;
      logic [63:0] a;
      split_offset(ofs, c, rest);
      a = c[0] * row_len + c[2];
      return int'(a % INDEX_DEPTH);
   endfunction

   function automatic gather_rsp_type resolve_source(input logic [OFS_BITS-1:0] ofs);
      logic [63:0] c [3];
      logic [63:0] rest;
      logic [63:0] sum;
      logic [VAL_BITS-1:0] raw;
      gather_rsp_type r;
      split_offset(ofs, c, rest);
      raw = index_mem[gather_slot(ofs)];
      r.src = '0;
      r.bad = 1'b1;
      if (!raw[VAL_BITS-1]) begin
         c[2] = 64'(raw);
         sum = rest + c[0] * strides[CSR_SRC_BATCH] + c[1] * strides[CSR_SRC_OUTER]
               + c[2] * strides[CSR_SRC_GATHER];
         if (sum < (64'd1 << ADDR_BITS)) begin
            r.src = sum[ADDR_BITS-1:0];
            r.bad = 1'b0;
         end
      end
      return r;
   endfunction

   // accept transactions, update the store model and check results
   always @(posedge clock) begin
      gather_rsp_type e;
      if (!reset) begin
         if (start && !busy) begin
            accepted++;
            if (cur.func == FUNC_WRITE)
               index_mem[cur.eaddr % INDEX_DEPTH] = cur.evalue;
            else
               expected_rsps.push_back(resolve_source(cur.ofs));
         end
         if (rsp_valid) begin
            if (expected_rsps.size() == 0) begin
               errors++;
               $display("%0t: unexpected result src %h bad %b", $realtime,
                        rsp_src_offset, rsp_bad_index);
            end else begin
               e = expected_rsps.pop_front();
               if (rsp_src_offset !== e.src) begin
                  errors++;
                  $display("%0t: src_offset expected %h actual %h", $realtime,
                           e.src, rsp_src_offset);
               end
               if (rsp_bad_index !== e.bad) begin
                  errors++;
                  $display("%0t: bad_index expected %b actual %b", $realtime,
                           e.bad, rsp_bad_index);
               end
            end
         end
      end
   end

   // request driver: hold until taken, then insert gaps or advance
   always @(negedge clock) begin
      if (!reset && !(start && issued != accepted)) begin
         if (gap > 0) begin
            gap--;
            start <= 1'b0;
         end else if (pending_reqs.size() > 0) begin
            cur = pending_reqs.pop_front();
            req_func <= cur.func;
            req_entry_addr <= cur.eaddr;
            req_entry_value <= cur.evalue;
            req_out_offset <= cur.ofs;
            start <= 1'b1;
            issued++;
            if (gaps_on && $urandom_range(0, 5) == 0)
               gap = $urandom_range(1, 7);
         end else begin
            start <= 1'b0;
         end
      end
   end

   task automatic csr_write(input logic [CSR_IDX_BITS-1:0] idx, input logic [31:0] data);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_ROW_LENGTH)
         row_len = data[ROW_BITS-1:0];
      else if (idx < CSR_ROW_LENGTH)
         strides[idx] = data[OFS_BITS-1:0];
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic push_write(input int slot, input logic [VAL_BITS-1:0] v);
      gather_req_type t;
      t.func = FUNC_WRITE;
      t.eaddr = EADDR_BITS'(slot);
      t.evalue = v;
      t.ofs = OFS_BITS'($urandom);
      slot_written[slot] = 1'b1;
      pending_reqs.push_back(t);
   endtask

   function automatic logic [VAL_BITS-1:0] pick_index();
      case ($urandom_range(0, 9))
         0: return $urandom | 32'h8000_0000;
         1: return $urandom & 32'h7FFF_FFFF;
         2: return $urandom_range(0, 1 << 20);
         default: return $urandom_range(0, 63);
      endcase
   endfunction

   // write the slot first if it was never written, so no unwritten read occurs, and sometimes at random
   task automatic push_resolve(input logic [OFS_BITS-1:0] ofs);
      gather_req_type t;
      int slot;
      slot = gather_slot(ofs);
      if (!slot_written[slot] || $urandom_range(0, 3) == 0)
         push_write(slot, pick_index());
      t.func = FUNC_RESOLVE;
      t.eaddr = EADDR_BITS'($urandom);
      t.evalue = $urandom;
      t.ofs = ofs;
      pending_reqs.push_back(t);
   endtask

   task automatic gen_phase(input int n, input int ofs_max);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 7) == 0)
            push_write($urandom_range(0, INDEX_DEPTH - 1), $urandom);
         else if ($urandom_range(0, 4) == 0)
            push_resolve(OFS_BITS'($urandom));
         else
            push_resolve(OFS_BITS'($urandom_range(0, ofs_max)));
      end
   endtask

   task automatic drain();
      do @(posedge clock);
      while (pending_reqs.size() != 0 || issued != accepted || expected_rsps.size() != 0);
      // writes in flight leave no result behind
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic random_layout();
      int inner, g, o, sinner, sg;
      inner = $urandom_range(1, 16);
      g = $urandom_range(1, 64);
      o = $urandom_range(1, 8);
      sinner = $urandom_range(1, 32);
      sg = $urandom_range(1, 256);
      csr_write(CSR_OUT_GATHER, inner);
      csr_write(CSR_OUT_OUTER, g * inner);
      csr_write(CSR_OUT_BATCH, o * g * inner);
      csr_write(CSR_SRC_GATHER, sinner);
      csr_write(CSR_SRC_OUTER, sg * sinner);
      csr_write(CSR_SRC_BATCH, o * sg * sinner);
      csr_write(CSR_ROW_LENGTH, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4096) : g);
   endtask

   initial begin
      for (int k = 0; k < 6; k++) strides[k] = 1;
      row_len = 1;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: reset layout, store edges, sign and range limits, wrap
      push_write(0, 32'd0);
      push_write(INDEX_DEPTH - 1, 32'h7FFF_FFFF);
      push_write(1, 32'hFFFF_FFFF);
      push_write(2, 32'h8000_0000);
      push_write(3, 32'd5);
      push_resolve(24'd0);
      push_resolve(24'd4095);
      push_resolve(24'd4096);
      push_resolve(24'd1);
      push_resolve(24'd2);
      push_resolve(24'd3);
      push_resolve(24'hFFFFFF);
      push_resolve(24'd4099);
      drain();

      // extremes: maximum strides, row length 4096, with masked wide data
      csr_write(CSR_OUT_BATCH, 32'hFFFF_FFFF);
      csr_write(CSR_OUT_OUTER, 32'h00FF_FFFF);
      csr_write(CSR_OUT_GATHER, 32'h00FF_FFFF);
      csr_write(CSR_SRC_BATCH, 32'hFFFF_FFFF);
      csr_write(CSR_SRC_OUTER, 32'h00FF_FFFF);
      csr_write(CSR_SRC_GATHER, 32'h00FF_FFFF);
      csr_write(CSR_ROW_LENGTH, 32'hFFFF_F000);
      csr_write(CSR_UNUSED, 32'hDEAD_BEEF);
      gen_phase(60, 24'hFFFFFF);
      drain();

      // zero strides and zero row length pass the remainder through
      csr_write(CSR_OUT_GATHER, 32'h0100_0000);
      csr_write(CSR_OUT_OUTER, 32'd0);
      csr_write(CSR_OUT_BATCH, 32'd7);
      csr_write(CSR_ROW_LENGTH, 32'h0000_2000);
      csr_write(CSR_SRC_GATHER, 32'hAB00_0003);
      gen_phase(40, 24'hFFFFFF);
      drain();

      for (int p = 0; p < 8; p++) begin
         random_layout();
         if (p == 7) gaps_on = 1'b0;
         gen_phase(75, strides[CSR_OUT_BATCH] * 8 - 1);
         drain();
      end

      if (errors == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      #(12 * 500000);
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
